// ----- hdl/latency_window_statistics_unit_assert.svh -----
// Assertion macros for the latency window statistics unit
`ifndef LATENCY_WINDOW_STATISTICS_UNIT_ASSERT_SVH
`define LATENCY_WINDOW_STATISTICS_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LWS_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lws assertion failed");

// next-cycle implication, disabled in reset
`define LWS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lws assertion failed");

`endif

// ----- hdl/lws_pkg.sv -----
// Package: types and constants of the latency window statistics unit
`timescale 1ns / 1ps
package lws_pkg;
	localparam int VAL_W   = 20;
	localparam int OCNT_W  = 7;
	localparam int QUAL_W  = 3;
	localparam int PCT_W   = 7;
	localparam int CIDX_W  = 3;
	localparam int VAR_W   = 2 * VAL_W;
	localparam int ROOT_ITERS = VAR_W / 2;
	localparam int HUNDRED = 100;

	typedef struct packed {
		logic             req_type;
		logic [VAL_W-1:0] sample_value;
	} in_item_t;

	typedef struct packed {
		logic [OCNT_W-1:0] entry_count;
		logic [OCNT_W-1:0] timeout_count;
		logic [VAL_W-1:0]  min_latency;
		logic [VAL_W-1:0]  max_latency;
		logic [VAL_W-1:0]  mean_latency;
		logic [VAL_W-1:0]  jitter;
		logic [QUAL_W-1:0] quality;
	} out_item_t;

	typedef enum logic [CIDX_W-1:0] {
		CFG_LOSS_CRIT = 3'd0,
		CFG_AVG_CRIT  = 3'd1,
		CFG_LOSS_POOR = 3'd2,
		CFG_AVG_POOR  = 3'd3,
		CFG_JIT_FAIR  = 3'd4,
		CFG_AVG_FAIR  = 3'd5,
		CFG_AVG_GOOD  = 3'd6
	} cfg_idx_e;

	typedef enum logic [QUAL_W-1:0] {
		Q_EXCELLENT = 3'd0,
		Q_GOOD      = 3'd1,
		Q_FAIR      = 3'd2,
		Q_POOR      = 3'd3,
		Q_CRITICAL  = 3'd4
	} quality_e;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WALK, ST_DRAIN1, ST_DRAIN2, ST_DRAIN3, ST_MUL_GO, ST_MUL,
		ST_DIVM_GO, ST_DIVM, ST_DIVV_GO, ST_DIVV, ST_ROOT_GO, ST_ROOT,
		ST_COMMIT, ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic walk_rd;
		logic mul_start;
		logic mul_step;
		logic div_start;
		logic div_sel_var;
		logic div_step;
		logic root_start;
		logic root_step;
		logic commit;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic walk_last;
		logic mul_done;
		logic div_done;
		logic root_done;
		logic has_valid;
	} status_t;
endpackage

// ----- hdl/lws_ctrl.sv -----
// Controller state machine sequencing walk, multiply, divide and root
`timescale 1ns / 1ps
module lws_ctrl
	import lws_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_free,
	input  status_t stat,
	output logic    idle,
	output cmd_t    cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:    if (in_valid) state_d = ST_WALK;
			ST_WALK:    if (stat.walk_last) state_d = ST_DRAIN1;
			ST_DRAIN1:  state_d = ST_DRAIN2;
			ST_DRAIN2:  state_d = ST_DRAIN3;
			ST_DRAIN3:  state_d = stat.has_valid ? ST_MUL_GO : ST_EMIT;
			ST_MUL_GO:  state_d = ST_MUL;
			ST_MUL:     if (stat.mul_done) state_d = ST_DIVM_GO;
			ST_DIVM_GO: state_d = ST_DIVM;
			ST_DIVM:    if (stat.div_done) state_d = ST_DIVV_GO;
			ST_DIVV_GO: state_d = ST_DIVV;
			ST_DIVV:    if (stat.div_done) state_d = ST_ROOT_GO;
			ST_ROOT_GO: state_d = ST_ROOT;
			ST_ROOT:    if (stat.root_done) state_d = ST_COMMIT;
			ST_COMMIT:  state_d = ST_EMIT;
			ST_EMIT:    if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		idle = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				cmd.load = in_valid;
			end
			ST_WALK:    cmd.walk_rd = 1'b1;
			ST_MUL_GO:  cmd.mul_start = 1'b1;
			ST_MUL:     cmd.mul_step = 1'b1;
			ST_DIVM_GO: cmd.div_start = 1'b1;
			ST_DIVM:    cmd.div_step = 1'b1;
			ST_DIVV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel_var = 1'b1;
			end
			ST_DIVV: begin
				cmd.div_step = 1'b1;
				cmd.div_sel_var = 1'b1;
			end
			ST_ROOT_GO: cmd.root_start = 1'b1;
			ST_ROOT:    cmd.root_step = 1'b1;
			ST_COMMIT:  cmd.commit = 1'b1;
			ST_EMIT:    cmd.emit = out_free;
			default:    cmd = '0;
		endcase
	end
endmodule

// ----- hdl/lws_dp.sv -----
// Datapath: history ring, window accumulators, serial multiply, divider and root
`timescale 1ns / 1ps
module lws_dp
	import lws_pkg::*;
#(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	input  in_item_t             item,
	output status_t              stat,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0] fill,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0] tmo,
	output logic [$clog2(HISTORY_DEPTH+1)-1:0] nvalid,
	output logic [VAL_W-1:0]     lo,
	output logic [VAL_W-1:0]     hi,
	output logic [VAL_W-1:0]     mean,
	output logic [VAL_W-1:0]     jit
);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int PTR_W = $clog2(HISTORY_DEPTH);
	localparam int ENT_W = VAL_W + 1;
	localparam int SUM_W = VAL_W + CNT_W;
	localparam int SQ_W  = 2 * VAL_W + CNT_W;
	localparam int NUM_W = SQ_W + CNT_W;
	localparam int DVS_W = 2 * CNT_W;
	localparam int DCNT_W = $clog2(NUM_W + 1);
	localparam int MCNT_W = $clog2(CNT_W + 1);
	localparam int RCNT_W = $clog2(ROOT_ITERS + 1);

	logic [ENT_W-1:0] ring [HISTORY_DEPTH];

	logic [PTR_W-1:0] oldest_q, rd_addr_q;
	logic [CNT_W-1:0] fill_q, rd_cnt_q;
	logic [VAL_W-1:0] held_mean_q, held_jit_q;
	logic [NUM_W-1:0] quo_q;
	logic [VAL_W-1:0] mean_q, root_q;

	logic             full;
	logic [CNT_W:0]   slot_sum;
	logic [PTR_W-1:0] slot, old_next, walk_start;
	logic [ENT_W-1:0] entry;

	assign full = fill_q == CNT_W'(HISTORY_DEPTH);
	assign slot_sum = (CNT_W+1)'(oldest_q) + (CNT_W+1)'(fill_q);
	assign old_next = (oldest_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign entry = item.req_type ? {1'b1, {VAL_W{1'b0}}} : {1'b0, item.sample_value};

	always_comb begin
		if (full) begin
			slot = oldest_q;
			walk_start = old_next;
		end else begin
			slot = (slot_sum >= (CNT_W+1)'(HISTORY_DEPTH)) ?
				PTR_W'(slot_sum - (CNT_W+1)'(HISTORY_DEPTH)) : PTR_W'(slot_sum);
			walk_start = oldest_q;
		end
	end

	// ring memory
	logic [ENT_W-1:0] rd_s1;
	logic             v_s1;
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ring[slot] <= entry;
		end
		if (cmd.walk_rd) begin
			rd_s1 <= ring[rd_addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			fill_q <= '0;
			rd_addr_q <= '0;
			rd_cnt_q <= '0;
			held_mean_q <= '0;
			held_jit_q <= '0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					oldest_q <= old_next;
				end else begin
					fill_q <= fill_q + 1'b1;
				end
				rd_addr_q <= walk_start;
				rd_cnt_q <= full ? fill_q : fill_q + 1'b1;
			end else if (cmd.walk_rd) begin
				rd_addr_q <= (rd_addr_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : rd_addr_q + 1'b1;
				rd_cnt_q <= rd_cnt_q - 1'b1;
			end
			if (cmd.commit) begin
				held_mean_q <= mean_q;
				held_jit_q <= root_q;
			end
		end
	end

	// walk pipeline: read, square, accumulate
	logic [VAL_W-1:0]   val_s2;
	logic [2*VAL_W-1:0] sq_s2;
	logic               v_s2, tmo_s2;
	logic [SUM_W-1:0]   sum_q;
	logic [SQ_W-1:0]    sumsq_q;
	logic [CNT_W-1:0]   tmo_q, nv_q;
	logic [VAL_W-1:0]   lo_q, hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.walk_rd;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		tmo_s2 <= rd_s1[ENT_W-1];
		val_s2 <= rd_s1[VAL_W-1:0];
		sq_s2 <= rd_s1[VAL_W-1:0] * rd_s1[VAL_W-1:0];
		if (cmd.load) begin
			sum_q <= '0;
			sumsq_q <= '0;
			tmo_q <= '0;
			nv_q <= '0;
			lo_q <= '1;
			hi_q <= '0;
		end else if (v_s2) begin
			if (tmo_s2) begin
				tmo_q <= tmo_q + 1'b1;
			end else begin
				sum_q <= sum_q + SUM_W'(val_s2);
				sumsq_q <= sumsq_q + SQ_W'(sq_s2);
				nv_q <= nv_q + 1'b1;
				if (val_s2 < lo_q) lo_q <= val_s2;
				if (val_s2 > hi_q) hi_q <= val_s2;
			end
		end
	end

	// serial n*Q; S*S and n*n registered at start
	logic [NUM_W-1:0]  nq_q, mq_q;
	logic [CNT_W-1:0]  mn_q;
	logic [MCNT_W-1:0] mcnt_q;
	logic [2*SUM_W-1:0] ss_q;
	logic [DVS_W-1:0]  nn_q;

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			nq_q <= '0;
			mq_q <= NUM_W'(sumsq_q);
			mn_q <= nv_q;
			mcnt_q <= MCNT_W'(CNT_W);
			ss_q <= sum_q * sum_q;
			nn_q <= nv_q * nv_q;
		end else if (cmd.mul_step) begin
			if (mn_q[0]) nq_q <= nq_q + mq_q;
			mq_q <= mq_q << 1;
			mn_q <= mn_q >> 1;
			mcnt_q <= mcnt_q - 1'b1;
		end
	end

	// restoring divider, one quotient bit a cycle
	logic [NUM_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q, rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [DVS_W:0]    trial;

	assign trial = {rem_q, dvd_q[NUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= '0;
			if (cmd.div_sel_var) begin
				dvd_q <= nq_q - NUM_W'(ss_q);
				dvs_q <= nn_q;
				dcnt_q <= DCNT_W'(NUM_W);
			end else begin
				dvd_q <= {sum_q, {(NUM_W-SUM_W){1'b0}}};
				dvs_q <= DVS_W'(nv_q);
				dcnt_q <= DCNT_W'(SUM_W);
			end
		end else if (cmd.div_step) begin
			dvd_q <= dvd_q << 1;
			dcnt_q <= dcnt_q - 1'b1;
			if (trial >= (DVS_W+1)'(dvs_q)) begin
				rem_q <= DVS_W'(trial - (DVS_W+1)'(dvs_q));
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= DVS_W'(trial);
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
			if (dcnt_q == DCNT_W'(1) && !cmd.div_sel_var) begin
				mean_q <= VAL_W'({quo_q[NUM_W-2:0], trial >= (DVS_W+1)'(dvs_q)});
			end
		end
	end

	// digit-by-digit square root, one result bit a cycle
	logic [VAR_W-1:0]  rx_q;
	logic [VAL_W:0]    rrem_q;
	logic [VAL_W+2:0]  rcur, rtry;
	logic [RCNT_W-1:0] rcnt_q;

	assign rcur = {rrem_q, rx_q[VAR_W-1 -: 2]};
	assign rtry = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			rx_q <= quo_q[VAR_W-1:0];
			rrem_q <= '0;
			root_q <= '0;
			rcnt_q <= RCNT_W'(ROOT_ITERS);
		end else if (cmd.root_step) begin
			rx_q <= rx_q << 2;
			rcnt_q <= rcnt_q - 1'b1;
			if (rcur >= rtry) begin
				rrem_q <= (VAL_W+1)'(rcur - rtry);
				root_q <= {root_q[VAL_W-2:0], 1'b1};
			end else begin
				rrem_q <= (VAL_W+1)'(rcur);
				root_q <= {root_q[VAL_W-2:0], 1'b0};
			end
		end
	end

	assign stat.walk_last = rd_cnt_q == CNT_W'(1);
	assign stat.mul_done  = mcnt_q == MCNT_W'(1);
	assign stat.div_done  = dcnt_q == DCNT_W'(1);
	assign stat.root_done = rcnt_q == RCNT_W'(1);
	assign stat.has_valid = nv_q != '0;

	assign fill   = fill_q;
	assign tmo    = tmo_q;
	assign nvalid = nv_q;
	assign lo     = lo_q;
	assign hi     = hi_q;
	assign mean   = held_mean_q;
	assign jit    = held_jit_q;
endmodule

// ----- hdl/latency_window_statistics_unit.sv -----
// Top level: configuration registers, grading, output register
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_item (in_item_t)
//  out     | output    | out_valid / out_ready | out_item (out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
// Each item passes the ring walk (one memory read a cycle), the serial n*Q
// multiply, the bit-serial divider run twice and the 20-step root before it is emitted.
// A window with no valid sample skips multiply, divide, root and commit, so the held
// mean and jitter are reported unchanged. No new item is taken until the last is emitted.
// Reset clears the window; ring contents stay unwritten until filled.
// The next item is taken while a result waits in the output register.
`timescale 1ns / 1ps
module latency_window_statistics_unit
	import lws_pkg::*;
#(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  in_item_t          in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output out_item_t         out_item,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CIDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]  cfg_data
);
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int PROD_W = PCT_W + CNT_W;

	logic [PCT_W-1:0] loss_crit_q, loss_poor_q;
	logic [VAL_W-1:0] avg_crit_q, avg_poor_q, jit_fair_q, avg_fair_q, avg_good_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loss_crit_q <= PCT_W'(10);
			avg_crit_q <= VAL_W'(8000);
			loss_poor_q <= PCT_W'(5);
			avg_poor_q <= VAL_W'(3200);
			jit_fair_q <= VAL_W'(1600);
			avg_fair_q <= VAL_W'(1600);
			avg_good_q <= VAL_W'(800);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LOSS_CRIT: loss_crit_q <= cfg_data[PCT_W-1:0];
				CFG_AVG_CRIT:  avg_crit_q <= cfg_data;
				CFG_LOSS_POOR: loss_poor_q <= cfg_data[PCT_W-1:0];
				CFG_AVG_POOR:  avg_poor_q <= cfg_data;
				CFG_JIT_FAIR:  jit_fair_q <= cfg_data;
				CFG_AVG_FAIR:  avg_fair_q <= cfg_data;
				CFG_AVG_GOOD:  avg_good_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cmd_t    cmd;
	status_t stat;
	logic    idle, out_free;
	logic [CNT_W-1:0] fill, tmo, nvalid;
	logic [VAL_W-1:0] lo, hi, mean, jit;

	assign out_free = !out_valid || out_ready;
	assign in_ready = idle;

	lws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.stat     (stat),
		.idle     (idle),
		.cmd      (cmd)
	);

	lws_dp #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.item   (in_item),
		.stat   (stat),
		.fill   (fill),
		.tmo    (tmo),
		.nvalid (nvalid),
		.lo     (lo),
		.hi     (hi),
		.mean   (mean),
		.jit    (jit)
	);

	logic [PROD_W-1:0] loss100, crit_lim, poor_lim;
	quality_e grade;

	assign loss100  = PROD_W'(tmo) * PROD_W'(HUNDRED);
	assign crit_lim = PROD_W'(loss_crit_q) * PROD_W'(fill);
	assign poor_lim = PROD_W'(loss_poor_q) * PROD_W'(fill);

	always_comb begin
		if (fill == '0) grade = Q_EXCELLENT;
		else if (loss100 > crit_lim || mean > avg_crit_q) grade = Q_CRITICAL;
		else if (loss100 > poor_lim || mean > avg_poor_q) grade = Q_POOR;
		else if (jit > jit_fair_q || mean > avg_fair_q) grade = Q_FAIR;
		else if (mean > avg_good_q) grade = Q_GOOD;
		else grade = Q_EXCELLENT;
	end

	out_item_t out_q;
	logic      out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.entry_count <= OCNT_W'(fill);
			out_q.timeout_count <= OCNT_W'(tmo);
			out_q.min_latency <= lo;
			out_q.max_latency <= hi;
			out_q.mean_latency <= mean;
			out_q.jitter <= jit;
			out_q.quality <= grade;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_q;

	`include "latency_window_statistics_unit_assert.svh"

	`LWS_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`LWS_ASSERT_NEXT(a_fill_nonzero, in_valid && in_ready, fill != '0)
	`LWS_ASSERT_IMPL(a_min_le_max, cmd.emit && nvalid != '0, lo <= hi)
	`LWS_ASSERT_IMPL(a_emit_free, cmd.emit, out_free && !idle)
endmodule
